/* src/lmbf_pkg.sv */
`timescale 1ns / 1ps

package lmbf_pkg;

  localparam int WIDTH       = 64;
  localparam int HEIGHT      = 32;
  localparam int PLANES      = 8;

  localparam int HALF_ROWS   = 16;
  localparam int LATCH_COL   = 62;
  localparam int STORE_DEPTH = WIDTH * HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(WIDTH);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EMIT  = 1'b1
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRIGHTNESS = 2'd0,
    CFG_SWAP       = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef logic [23:0] pixel_t;

  // pick one bit of each channel, returned as {b, g, r}
  function automatic logic [2:0] colour_bits(input pixel_t c, input logic [2:0] bit_idx);
    logic [2:0] v;
    v[0] = c[5'd16 + 5'(bit_idx)];
    v[1] = c[5'd8 + 5'(bit_idx)];
    v[2] = c[bit_idx];
    return v;
  endfunction

endpackage

/* src/led_matrix_bitplane_formatter.sv */
`timescale 1ns / 1ps

// HUB75 bitplane formatter. A write item (opcode 0) stores one 24-bit pixel into the
// WIDTH x HEIGHT frame store and returns no result. An emit item (opcode 1) walks the
// columns of one scan row of one bitplane and returns WIDTH panel words, the final one
// flagged by last_o. The column sequencer issues one frame store read per cycle while
// the output is not stalled, fetching the upper and the lower pixel together on the
// store's two read ports; an emit holds off the input until its last column is issued.
// Words pass through the read stage into the output register, then follow one per cycle
// while the output is not stalled. Output stall throttles the read sequencer, no loss.
// Pixels must be written before they are emitted: the frame store has no reset. The user
// must write brightness and column swap only while the block is quiet; it is not checked.

module led_matrix_bitplane_formatter
  import lmbf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [5:0]            pixel_x_i,
  input  logic [4:0]            pixel_y_i,
  input  logic [23:0]           color_i,
  input  logic [2:0]            plane_i,
  input  logic [3:0]            scan_row_i,

  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           panel_word_o,
  output logic                  last_o,

  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // configuration
  logic [5:0] brightness_q;
  logic       swap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= 6'd16;
      swap_q       <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_BRIGHTNESS: brightness_q <= cfg_data_i[5:0];
        CFG_SWAP:       swap_q       <= cfg_data_i[0];
        default:        ;  // unknown index, ignored
      endcase
    end
  end

  // sequencer state
  state_e           state_q, state_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [2:0]       em_bit_q;
  logic [3:0]       em_row_q;
  logic [3:0]       em_raddr_q;

  // read stage
  logic             rd_vld_q, rd_vld_d;
  logic [COL_W-1:0] rd_col_q;
  logic [2:0]       rd_bit_q;
  logic [3:0]       rd_raddr_q;
  logic             rd_up_ok_q, rd_lo_ok_q;
  pixel_t           rd_up_q, rd_lo_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [15:0]      word_q;
  logic             last_q;

  logic in_accept, wr_en, emit_start, issue, out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign wr_en      = in_accept && (opcode_i == OP_WRITE)
                      && (int'(pixel_x_i) < WIDTH) && (int'(pixel_y_i) < HEIGHT);
  assign emit_start = in_accept && (opcode_i == OP_EMIT);

  assign out_load = rd_vld_q && (!out_valid_q || !out_stall_i);
  assign issue    = (state_q == ST_EMIT) && (!rd_vld_q || out_load);

  // plane saturation and bit select
  logic [3:0] plane_sat;
  logic [2:0] bit_sel;
  always_comb begin
    if (int'(plane_i) >= PLANES) begin
      plane_sat = 4'(PLANES - 1);
    end else begin
      plane_sat = {1'b0, plane_i};
    end
    bit_sel = 3'(4'(8 - PLANES) + plane_sat);
  end

  // read addresses for the current column, upper and lower half
  logic [COL_W-1:0] rd_x;
  logic [4:0]       lo_row;
  logic             x_ok, up_ok, lo_ok;
  logic [ADDR_W-1:0] up_addr, lo_addr, wr_addr;

  always_comb begin
    rd_x    = swap_q ? (col_q ^ COL_W'(1)) : col_q;
    lo_row  = {1'b0, em_row_q} + 5'(HALF_ROWS);
    x_ok    = int'(rd_x) < WIDTH;
    up_ok   = x_ok && (int'(em_row_q) < HEIGHT);
    lo_ok   = x_ok && (int'(lo_row) < HEIGHT);
    up_addr = up_ok ? ADDR_W'(ADDR_W'(em_row_q) * ADDR_W'(WIDTH) + ADDR_W'(rd_x)) : '0;
    lo_addr = lo_ok ? ADDR_W'(ADDR_W'(lo_row) * ADDR_W'(WIDTH) + ADDR_W'(rd_x)) : '0;
    wr_addr = ADDR_W'(ADDR_W'(pixel_y_i) * ADDR_W'(WIDTH) + ADDR_W'(pixel_x_i));
  end

  // frame store: one write port, two registered read ports
  pixel_t frame_mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_mem[wr_addr] <= color_i;
    end
    if (issue) begin
      rd_up_q <= frame_mem[up_addr];
      rd_lo_q <= frame_mem[lo_addr];
    end
  end

  // column sequencer
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    case (state_q)
      ST_IDLE: begin
        if (emit_start) begin
          state_d = ST_EMIT;
          col_d   = '0;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          col_d = col_q + COL_W'(1);
          if (col_q == COL_W'(WIDTH - 1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
    end
  end

  // emit parameters latched at accept
  always_ff @(posedge clk_i) begin
    if (emit_start) begin
      em_bit_q   <= bit_sel;
      em_row_q   <= scan_row_i;
      em_raddr_q <= scan_row_i - 4'd1;  // row zero wraps to 15
    end
  end

  // read stage, carries the column context along with the fetched pixels
  always_comb begin
    rd_vld_d = rd_vld_q;
    if (issue) begin
      rd_vld_d = 1'b1;
    end else if (out_load) begin
      rd_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_col_q   <= col_q;
      rd_bit_q   <= em_bit_q;
      rd_raddr_q <= em_raddr_q;
      rd_up_ok_q <= up_ok;
      rd_lo_ok_q <= lo_ok;
    end
  end

  // word assembly
  logic [15:0] word_d;
  logic        last_d;
  always_comb begin
    word_d        = '0;
    word_d[11:8]  = rd_raddr_q;
    word_d[12]    = (int'(rd_col_q) == LATCH_COL);
    word_d[13]    = (rd_col_q == '0) || (int'(rd_col_q) >= int'(brightness_q));
    word_d[2:0]   = rd_up_ok_q ? colour_bits(rd_up_q, rd_bit_q) : 3'b000;
    word_d[5:3]   = rd_lo_ok_q ? colour_bits(rd_lo_q, rd_bit_q) : 3'b000;
    last_d        = (rd_col_q == COL_W'(WIDTH - 1));
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      word_q <= word_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign panel_word_o = word_q;
  assign last_o       = last_q;

endmodule

/* src/lmbf_checker.sv */
`timescale 1ns / 1ps

module lmbf_checker
  import lmbf_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  opcode_i,
  input logic [5:0]            pixel_x_i,
  input logic [4:0]            pixel_y_i,
  input logic [23:0]           color_i,
  input logic [2:0]            plane_i,
  input logic [3:0]            scan_row_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [15:0]           panel_word_o,
  input logic                  last_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(panel_word_o) && $stable(last_o))
    else $error("stalled output item changed");

  // unused word bits stay low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (panel_word_o[7:6] == 2'b00) && (panel_word_o[15:14] == 2'b00))
    else $error("reserved panel word bits set");

  // final column always lies outside the brightness window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> panel_word_o[12] == 1'b0 && panel_word_o[13])
    else $error("final word without blanking or with latch");

  // an accepted emit holds off the next item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == OP_EMIT |=> in_stall_o)
    else $error("emit accepted without going busy");

endmodule

bind led_matrix_bitplane_formatter lmbf_checker u_lmbf_checker (.*);
